// ===== sv/smlma_pkg.sv =====
// ----------------------------------------------------------------------------
// smlma_pkg
// Shared types and codes for the sign-magnitude multi-limb accumulator.
// ----------------------------------------------------------------------------
package smlma_pkg;

  localparam int FRAC_PORT_W    = 36;
  localparam int LIMB_W         = 20;
  localparam int OP_LIMB_FIELDS = 4;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD = 2'd0;
  localparam cmd_t CMD_ADD  = 2'd1;
  localparam cmd_t CMD_SUB  = 2'd2;

  typedef logic [1:0] lane_mode_t;
  localparam lane_mode_t LM_ADD    = 2'd0;
  localparam lane_mode_t LM_SUB_AB = 2'd1;
  localparam lane_mode_t LM_SUB_BA = 2'd2;

  typedef struct packed {
    logic add_g;
    logic add_p;
    logic lt;
    logic eq;
  } lane_flags_t;

  typedef struct packed {
    lane_mode_t mode;
    logic       overflow;
  } merge_ctrl_t;

  typedef struct packed {
    logic                                     negative;
    logic [FRAC_PORT_W-1:0]                   fraction;
    logic [OP_LIMB_FIELDS-1:0][LIMB_W-1:0]    limb;
    logic                                     overflow;
  } result_t;

endpackage

// ===== sv/smlma_lane.sv =====
// ----------------------------------------------------------------------------
// smlma_lane
// One digit lane: carry and borrow flags, and the digit for a given carry in.
// ----------------------------------------------------------------------------
module smlma_lane #(
  parameter int          W     = 20,
  parameter logic [63:0] RADIX = 64'd1000000
) (
  input  logic [W-1:0]            a,
  input  logic [W-1:0]            b,
  input  smlma_pkg::lane_mode_t   mode,
  input  logic                    cin,
  output smlma_pkg::lane_flags_t  flags,
  output logic [W-1:0]            digit
);
  import smlma_pkg::*;

  localparam logic [W:0] RAD = (W+1)'(RADIX);

  logic [W:0] a_x;
  logic [W:0] b_x;
  logic [W:0] ab;
  logic [W:0] s;
  logic [W:0] x;
  logic [W:0] y;
  logic [W:0] t;

  assign a_x = {1'b0, a};
  assign b_x = {1'b0, b};
  assign ab  = a_x + b_x;

  assign flags.add_g = (ab >= RAD);
  assign flags.add_p = (ab == (RAD - (W+1)'(1)));
  assign flags.lt    = (a < b);
  assign flags.eq    = (a == b);

  always_comb begin
    s = ab + (W+1)'(cin);
    if (mode == LM_SUB_BA) begin
      x = b_x;
      y = a_x;
    end else begin
      x = a_x;
      y = b_x;
    end
    t = y + (W+1)'(cin);
    case (mode)
      LM_ADD:  digit = (s >= RAD) ? W'(s - RAD) : W'(s);
      default: digit = (x >= t) ? W'(x - t) : W'(x + RAD - t);
    endcase
  end

endmodule

// ===== sv/smlma_merge.sv =====
// ----------------------------------------------------------------------------
// smlma_merge
// Resolve carry and borrow chains across lanes and pick the operation.
// ----------------------------------------------------------------------------
module smlma_merge #(
  parameter int DIGITS = 5
) (
  input  smlma_pkg::lane_flags_t [DIGITS-1:0] flags,
  input  logic                                do_add,
  output logic [DIGITS-1:0]                   cin,
  output smlma_pkg::merge_ctrl_t              ctrl
);
  import smlma_pkg::*;

  logic [DIGITS:0] c_add;
  logic [DIGITS:0] b_ab;
  logic [DIGITS:0] b_ba;

  always_comb begin
    c_add[0] = 1'b0;
    b_ab[0]  = 1'b0;
    b_ba[0]  = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      c_add[i+1] = flags[i].add_g | (flags[i].add_p & c_add[i]);
      b_ab[i+1]  = flags[i].lt | (flags[i].eq & b_ab[i]);
      b_ba[i+1]  = (~flags[i].lt & ~flags[i].eq) | (flags[i].eq & b_ba[i]);
    end
    ctrl.overflow = do_add & c_add[DIGITS];
    if (do_add) begin
      ctrl.mode = LM_ADD;
    end else if (b_ab[DIGITS]) begin
      ctrl.mode = LM_SUB_BA;
    end else begin
      ctrl.mode = LM_SUB_AB;
    end
    case (ctrl.mode)
      LM_ADD:    cin = c_add[DIGITS-1:0];
      LM_SUB_BA: cin = b_ba[DIGITS-1:0];
      default:   cin = b_ab[DIGITS-1:0];
    endcase
  end

endmodule

// ===== sv/sign_magnitude_multilimb_accumulator.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_multilimb_accumulator
// Sign-magnitude accumulator over a fixed-point fraction and integer limbs.
// ----------------------------------------------------------------------------
// Input beats carry a command (load, add, subtract) and a signed operand made
// of a fraction digit and four integer limbs. Each accepted beat updates the
// accumulator and yields exactly one result beat holding the new value and
// an overflow flag. Out-of-range operand digits saturate to the largest
// legal digit; an unused command leaves the value unchanged.
// One lane per digit works out flags and the digit in parallel; a merging
// stage resolves the carry or borrow chain and the magnitude compare, so an
// item completes in the cycle it is accepted.
// Each result beat leaves the block from a registered output stage.
// Throughput: one beat per cycle while in_stall is low; the carry chain
// across the digit lanes sets the cycle time.
// Reset clears the accumulator to positive zero and empties the output.
// When the receiver stalls, one further result is parked in a skid register
// and in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module sign_magnitude_multilimb_accumulator #(
  parameter int unsigned LIMB_BASE     = 1000000,
  parameter int unsigned LIMB_COUNT    = 4,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic                                in_op_negative,
  input  logic [smlma_pkg::FRAC_PORT_W-1:0]   in_op_fraction,
  input  logic [smlma_pkg::LIMB_W-1:0]        in_op_limb0,
  input  logic [smlma_pkg::LIMB_W-1:0]        in_op_limb1,
  input  logic [smlma_pkg::LIMB_W-1:0]        in_op_limb2,
  input  logic [smlma_pkg::LIMB_W-1:0]        in_op_limb3,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_result_negative,
  output logic [smlma_pkg::FRAC_PORT_W-1:0]   out_result_fraction,
  output logic [smlma_pkg::LIMB_W-1:0]        out_result_limb0,
  output logic [smlma_pkg::LIMB_W-1:0]        out_result_limb1,
  output logic [smlma_pkg::LIMB_W-1:0]        out_result_limb2,
  output logic [smlma_pkg::LIMB_W-1:0]        out_result_limb3,
  output logic                                out_overflow
);
  import smlma_pkg::*;

  localparam int          DIGITS     = int'(LIMB_COUNT) + 1;
  localparam logic [63:0] FRAC_RADIX = 64'(LIMB_BASE) << FRACTION_BITS;
  localparam int          FRAC_NEED  = $clog2(FRAC_RADIX);
  localparam int          DW0        = (FRAC_NEED > FRAC_PORT_W) ? FRAC_NEED : FRAC_PORT_W;
  localparam logic [DW0-1:0]    FRAC_MAX = DW0'(FRAC_RADIX - 64'd1);
  localparam logic [LIMB_W-1:0] LIMB_MAX = LIMB_W'(LIMB_BASE - 1);

  logic                                  acc_sign_r;
  logic [DW0-1:0]                        acc_frac_r;
  logic [LIMB_COUNT-1:0][LIMB_W-1:0]     acc_limb_r;

  logic                                  acc_sign_nxt;
  logic [DW0-1:0]                        acc_frac_nxt;
  logic [LIMB_COUNT-1:0][LIMB_W-1:0]     acc_limb_nxt;

  logic [OP_LIMB_FIELDS-1:0][LIMB_W-1:0] op_limb_in;
  logic [DW0-1:0]                        op_frac;
  logic [LIMB_COUNT-1:0][LIMB_W-1:0]     op_limb;

  lane_flags_t [DIGITS-1:0]              flags;
  logic [DIGITS-1:0]                     cin;
  merge_ctrl_t                           ctrl;
  logic [DW0-1:0]                        lane_frac;
  logic [LIMB_COUNT-1:0][LIMB_W-1:0]     lane_limb;

  logic                                  in_accept;
  logic                                  eff_neg;
  logic                                  do_add;
  logic                                  is_arith;
  logic                                  sign_pre;
  logic                                  mag_zero;
  result_t                               new_res;

  logic                                  out_valid_r;
  result_t                               out_r;
  logic                                  skid_full_r;
  result_t                               skid_r;

  assign op_limb_in = {in_op_limb3, in_op_limb2, in_op_limb1, in_op_limb0};
  assign op_frac    = (DW0'(in_op_fraction) > FRAC_MAX) ? FRAC_MAX : DW0'(in_op_fraction);

  assign in_accept = in_valid & ~in_stall;
  assign in_stall  = skid_full_r;
  assign is_arith  = (in_cmd == CMD_ADD) | (in_cmd == CMD_SUB);
  assign eff_neg   = in_op_negative ^ (in_cmd == CMD_SUB);
  assign do_add    = (eff_neg == acc_sign_r);

  smlma_lane #(
    .W     (DW0),
    .RADIX (FRAC_RADIX)
  ) u_lane_frac (
    .a     (acc_frac_r),
    .b     (op_frac),
    .mode  (ctrl.mode),
    .cin   (cin[0]),
    .flags (flags[0]),
    .digit (lane_frac)
  );

  for (genvar i = 0; i < LIMB_COUNT; i++) begin : g_limb
    if (i < OP_LIMB_FIELDS) begin : g_field
      assign op_limb[i] = (op_limb_in[i] > LIMB_MAX) ? LIMB_MAX : op_limb_in[i];
    end else begin : g_nofield
      assign op_limb[i] = '0;
    end

    smlma_lane #(
      .W     (LIMB_W),
      .RADIX (64'(LIMB_BASE))
    ) u_lane (
      .a     (acc_limb_r[i]),
      .b     (op_limb[i]),
      .mode  (ctrl.mode),
      .cin   (cin[i+1]),
      .flags (flags[i+1]),
      .digit (lane_limb[i])
    );
  end

  smlma_merge #(
    .DIGITS (DIGITS)
  ) u_merge (
    .flags  (flags),
    .do_add (do_add),
    .cin    (cin),
    .ctrl   (ctrl)
  );

  always_comb begin
    case (in_cmd)
      CMD_LOAD: begin
        acc_frac_nxt = op_frac;
        acc_limb_nxt = op_limb;
        sign_pre     = in_op_negative;
      end
      CMD_ADD, CMD_SUB: begin
        acc_frac_nxt = lane_frac;
        acc_limb_nxt = lane_limb;
        sign_pre     = (ctrl.mode == LM_SUB_BA) ? eff_neg : acc_sign_r;
      end
      default: begin
        acc_frac_nxt = acc_frac_r;
        acc_limb_nxt = acc_limb_r;
        sign_pre     = acc_sign_r;
      end
    endcase
    mag_zero     = ~(|acc_frac_nxt) & ~(|acc_limb_nxt);
    acc_sign_nxt = sign_pre & ~mag_zero;

    new_res.negative = acc_sign_nxt;
    new_res.fraction = acc_frac_nxt[FRAC_PORT_W-1:0];
    new_res.overflow = is_arith & ctrl.overflow;
    for (int j = 0; j < OP_LIMB_FIELDS; j++) begin
      new_res.limb[j] = (j < int'(LIMB_COUNT)) ? acc_limb_nxt[j] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_sign_r <= 1'b0;
      acc_frac_r <= '0;
      acc_limb_r <= '0;
    end else if (in_accept) begin
      acc_sign_r <= acc_sign_nxt;
      acc_frac_r <= acc_frac_nxt;
      acc_limb_r <= acc_limb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      if (skid_full_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= new_res;
      end
    end else if (in_accept) begin
      skid_r <= new_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_negative = out_r.negative;
  assign out_result_fraction = out_r.fraction;
  assign out_result_limb0    = out_r.limb[0];
  assign out_result_limb1    = out_r.limb[1];
  assign out_result_limb2    = out_r.limb[2];
  assign out_result_limb3    = out_r.limb[3];
  assign out_overflow        = out_r.overflow;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_zero_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_frac_r == '0 && acc_limb_r == '0) |-> !acc_sign_r)
    else $error("zero accumulator carries a negative sign");

  a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    acc_frac_r <= FRAC_MAX)
    else $error("fraction digit at or above its radix");

  a_ovf_add_only: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && new_res.overflow) |-> (ctrl.mode == LM_ADD && is_arith))
    else $error("overflow raised outside a magnitude add");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !skid_full_r && (!out_valid_r || !out_stall)) |=> out_valid_r)
    else $error("accepted beat did not reach the output register");

endmodule

// ===== tb/smlma_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// smlma_tb_pkg
// Operand beat type and result scoreboard for the accumulator bench.
// ----------------------------------------------------------------------------
// The scoreboard keeps its own sign and digit vector and updates them for
// every operand beat taken by the block. Each update queues the value that
// the block must return. Result beats are checked field by field against
// the oldest queued value.
// ----------------------------------------------------------------------------
package smlma_tb_pkg;

  import smlma_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam longint unsigned LIMB_RADIX = 64'd1000000;
  localparam longint unsigned FRAC_RADIX = LIMB_RADIX << 16;
  localparam longint unsigned FRAC_TOP   = FRAC_RADIX - 1;
  localparam longint unsigned LIMB_TOP   = LIMB_RADIX - 1;
  localparam int              DIGITS     = OP_LIMB_FIELDS + 1;

  // digit 0 is the fraction, digits 1..4 the integer limbs
  typedef bit [DIGITS-1:0][39:0] magnitude_t;

  typedef struct packed {
    cmd_t                                  cmd;
    logic                                  negative;
    logic [FRAC_PORT_W-1:0]                fraction;
    logic [OP_LIMB_FIELDS-1:0][LIMB_W-1:0] limb;
  } operand_beat_t;

  class accumulator_scoreboard;

    bit         acc_negative;
    magnitude_t acc_mag;
    result_t    expected_values[$];
    int         errors;
    int         checked;
    int         overflows;
    int         zeros;
    int         cmd_seen[4];

    function new();
      acc_negative = 1'b0;
      acc_mag      = '0;
      errors       = 0;
      checked      = 0;
      overflows    = 0;
      zeros        = 0;
      cmd_seen     = '{default: 0};
    endfunction

    static function longint unsigned radix(int pos);
      return (pos == 0) ? FRAC_RADIX : LIMB_RADIX;
    endfunction

    static function int compare_mag(magnitude_t a, magnitude_t b);
      for (int i = DIGITS - 1; i >= 0; i--) begin
        if (a[i] > b[i]) return 1;
        if (a[i] < b[i]) return -1;
      end
      return 0;
    endfunction

    static function magnitude_t add_mag(magnitude_t a, magnitude_t b, output bit carry);
      magnitude_t      r;
      longint unsigned s;
      carry = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        s = a[i] + b[i] + carry;
        if (s >= radix(i)) begin
          s     = s - radix(i);
          carry = 1'b1;
        end else begin
          carry = 1'b0;
        end
        r[i] = s[39:0];
      end
      return r;
    endfunction

    // a must not be below b
    static function magnitude_t sub_mag(magnitude_t a, magnitude_t b);
      magnitude_t      r;
      longint unsigned t;
      bit              borrow;
      borrow = 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        t = b[i] + borrow;
        if (a[i] >= t) begin
          r[i]   = 40'(a[i] - t);
          borrow = 1'b0;
        end else begin
          r[i]   = 40'(a[i] + radix(i) - t);
          borrow = 1'b1;
        end
      end
      return r;
    endfunction

    function void take_operand(operand_beat_t b);
      magnitude_t op;
      magnitude_t res;
      bit         eff;
      bit         carry;
      bit         sign;
      result_t    want;
      op[0] = (b.fraction > FRAC_TOP) ? 40'(FRAC_TOP) : 40'(b.fraction);
      for (int i = 0; i < OP_LIMB_FIELDS; i++)
        op[i+1] = (b.limb[i] > LIMB_TOP) ? 40'(LIMB_TOP) : 40'(b.limb[i]);
      res   = acc_mag;
      sign  = acc_negative;
      carry = 1'b0;
      cmd_seen[b.cmd]++;
      case (b.cmd)
        CMD_LOAD: begin
          res  = op;
          sign = b.negative;
        end
        CMD_ADD, CMD_SUB: begin
          eff = b.negative ^ (b.cmd == CMD_SUB);
          if (eff == acc_negative) begin
            res = add_mag(acc_mag, op, carry);
          end else if (compare_mag(acc_mag, op) >= 0) begin
            res = sub_mag(acc_mag, op);
          end else begin
            res  = sub_mag(op, acc_mag);
            sign = eff;
          end
        end
        default: ;
      endcase
      if (res == '0) begin
        sign = 1'b0;
        zeros++;
      end
      overflows += carry;
      acc_negative = sign;
      acc_mag      = res;
      want.negative = sign;
      want.fraction = res[0][FRAC_PORT_W-1:0];
      for (int i = 0; i < OP_LIMB_FIELDS; i++)
        want.limb[i] = res[i+1][LIMB_W-1:0];
      want.overflow = carry;
      expected_values.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_values.size() == 0) begin
        $error("result beat arrived with nothing expected");
        errors++;
        return;
      end
      want = expected_values.pop_front();
      checked++;
      compare_field("result_negative", want.negative, got.negative);
      compare_field("result_fraction", want.fraction, got.fraction);
      for (int i = 0; i < OP_LIMB_FIELDS; i++)
        compare_field($sformatf("result_limb%0d", i), want.limb[i], got.limb[i]);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

  endclass

endpackage

// ===== tb/sign_magnitude_multilimb_accumulator_tb.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_multilimb_accumulator_tb
// Self-checking bench for the sign-magnitude multi-limb accumulator.
// ----------------------------------------------------------------------------
// A short directed sequence hits wrap-around on overflow, saturation of
// out-of-range digits, cancellation to positive zero, long borrow chains,
// sign flips and the unused command. Random operand beats follow, a share
// of them mirroring the running value to force cancellation and near-equal
// compares. Both channels idle at random in several styles, and the sender
// drains the block now and then. Every result beat goes to the scoreboard.
// ----------------------------------------------------------------------------
module sign_magnitude_multilimb_accumulator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import smlma_pkg::*;
  import smlma_tb_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_HEAVY, IDLE_SPARSE} idle_style_t;

  logic                                clk            = 1'b0;
  logic                                rst_n          = 1'b0;
  logic                                in_valid       = 1'b0;
  logic                                in_stall;
  cmd_t                                in_cmd         = CMD_LOAD;
  logic                                in_op_negative = 1'b0;
  logic [FRAC_PORT_W-1:0]              in_op_fraction = '0;
  logic [LIMB_W-1:0]                   in_op_limb0    = '0;
  logic [LIMB_W-1:0]                   in_op_limb1    = '0;
  logic [LIMB_W-1:0]                   in_op_limb2    = '0;
  logic [LIMB_W-1:0]                   in_op_limb3    = '0;
  logic                                out_valid;
  logic                                out_stall      = 1'b0;
  logic                                out_result_negative;
  logic [FRAC_PORT_W-1:0]              out_result_fraction;
  logic [LIMB_W-1:0]                   out_result_limb0;
  logic [LIMB_W-1:0]                   out_result_limb1;
  logic [LIMB_W-1:0]                   out_result_limb2;
  logic [LIMB_W-1:0]                   out_result_limb3;
  logic                                out_overflow;

  idle_style_t           idle_style = IDLE_SPARSE;
  accumulator_scoreboard sb         = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sign_magnitude_multilimb_accumulator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_op_negative      (in_op_negative),
    .in_op_fraction      (in_op_fraction),
    .in_op_limb0         (in_op_limb0),
    .in_op_limb1         (in_op_limb1),
    .in_op_limb2         (in_op_limb2),
    .in_op_limb3         (in_op_limb3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_negative (out_result_negative),
    .out_result_fraction (out_result_fraction),
    .out_result_limb0    (out_result_limb0),
    .out_result_limb1    (out_result_limb1),
    .out_result_limb2    (out_result_limb2),
    .out_result_limb3    (out_result_limb3),
    .out_overflow        (out_overflow)
  );

  function automatic int draw_wait();
    case (idle_style)
      IDLE_NONE:   return 0;
      IDLE_HEAVY:  return $urandom_range(0, 18);
      default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  always @(posedge clk) begin : beat_monitor
    operand_beat_t op;
    result_t       res;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        op.cmd      = in_cmd;
        op.negative = in_op_negative;
        op.fraction = in_op_fraction;
        op.limb     = {in_op_limb3, in_op_limb2, in_op_limb1, in_op_limb0};
        sb.take_operand(op);
      end
      if (out_valid && !out_stall) begin
        res.negative = out_result_negative;
        res.fraction = out_result_fraction;
        res.limb     = {out_result_limb3, out_result_limb2, out_result_limb1, out_result_limb0};
        res.overflow = out_overflow;
        sb.check_result(res);
      end
    end
  end

  initial begin : result_sink
    int n;
    wait (rst_n);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_beat(operand_beat_t b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= b.cmd;
    in_op_negative <= b.negative;
    in_op_fraction <= b.fraction;
    in_op_limb0    <= b.limb[0];
    in_op_limb1    <= b.limb[1];
    in_op_limb2    <= b.limb[2];
    in_op_limb3    <= b.limb[3];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic apply_operand(cmd_t c, int neg, longint unsigned f,
                               longint unsigned l0, longint unsigned l1,
                               longint unsigned l2, longint unsigned l3);
    operand_beat_t b;
    b.cmd      = c;
    b.negative = neg[0];
    b.fraction = f[FRAC_PORT_W-1:0];
    b.limb     = {l3[LIMB_W-1:0], l2[LIMB_W-1:0], l1[LIMB_W-1:0], l0[LIMB_W-1:0]};
    send_beat(b);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic longint unsigned pick_digit(longint unsigned top, int w);
    longint unsigned wide;
    int              r;
    wide = {$urandom(), $urandom()};
    r    = $urandom_range(0, 15);
    if (r < 3) return 0;
    if (r < 5) return top;
    if (r < 7) return top - (wide % 4);
    if (r == 7) return top + 1 + wide % ((64'd1 << w) - 1 - top);
    if (r == 8) return wide % 4;
    return wide % (top + 1);
  endfunction

  function automatic operand_beat_t random_operand();
    operand_beat_t b;
    int            k;
    int            pos;
    k          = $urandom_range(0, 99);
    b.negative = 1'($urandom_range(0, 1));
    b.fraction = FRAC_PORT_W'(pick_digit(FRAC_TOP, FRAC_PORT_W));
    for (int i = 0; i < OP_LIMB_FIELDS; i++)
      b.limb[i] = LIMB_W'(pick_digit(LIMB_TOP, LIMB_W));
    if (k < 12) begin
      b.cmd = CMD_LOAD;
    end else if (k < 48) begin
      b.cmd = CMD_ADD;
    end else if (k < 84) begin
      b.cmd = CMD_SUB;
    end else if (k < 95) begin
      // mirror the running value, mostly with the opposite effective sign
      b.cmd      = $urandom_range(0, 1) ? CMD_ADD : CMD_SUB;
      b.negative = sb.acc_negative ^ (b.cmd == CMD_SUB) ^ ($urandom_range(0, 3) != 0);
      b.fraction = sb.acc_mag[0][FRAC_PORT_W-1:0];
      for (int i = 0; i < OP_LIMB_FIELDS; i++)
        b.limb[i] = sb.acc_mag[i+1][LIMB_W-1:0];
      if ($urandom_range(0, 1)) begin
        pos = $urandom_range(0, OP_LIMB_FIELDS);
        if (pos == 0)
          b.fraction = (b.fraction == '0) ? FRAC_PORT_W'(1) : b.fraction - FRAC_PORT_W'(1);
        else
          b.limb[pos-1] = (b.limb[pos-1] == '0) ? LIMB_W'(1) : b.limb[pos-1] - LIMB_W'(1);
      end
    end else begin
      b.cmd = CMD_UNUSED;
    end
    return b;
  endfunction

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_style = IDLE_SPARSE;
    apply_operand(CMD_LOAD,   1, 0, 0, 0, 0, 0);
    apply_operand(CMD_LOAD,   0, FRAC_TOP, LIMB_TOP, LIMB_TOP, LIMB_TOP, LIMB_TOP);
    apply_operand(CMD_ADD,    0, 1, 0, 0, 0, 0);
    apply_operand(CMD_LOAD,   1, FRAC_TOP, LIMB_TOP, LIMB_TOP, LIMB_TOP, LIMB_TOP);
    apply_operand(CMD_SUB,    0, 2, 0, 0, 0, 0);
    apply_operand(CMD_LOAD,   0, (64'd1 << 36) - 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    apply_operand(CMD_ADD,    1, (64'd1 << 36) - 1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    apply_operand(CMD_LOAD,   0, 0, 0, 1, 0, 0);
    apply_operand(CMD_SUB,    0, 1, 0, 0, 0, 0);
    apply_operand(CMD_SUB,    0, 0, 0, 5, 0, 0);
    apply_operand(CMD_ADD,    1, 0, 0, 0, 0, 0);
    apply_operand(CMD_UNUSED, 1, FRAC_TOP, 1, 2, 3, 4);
    apply_operand(CMD_LOAD,   1, 32768, 0, 0, 0, 0);
    apply_operand(CMD_ADD,    0, 32768, 0, 0, 0, 0);
    apply_operand(CMD_SUB,    1, 0, 0, 0, 0, LIMB_TOP);
    apply_operand(CMD_ADD,    0, 0, 0, 0, 0, 1);
    apply_operand(CMD_LOAD,   0, 12345, 1, 2, 3, 4);
    apply_operand(CMD_SUB,    1, 54321, 4, 3, 2, 1);
    apply_operand(CMD_LOAD,   1, 100, 7, 7, 7, 7);
    apply_operand(CMD_ADD,    0, 101, 7, 7, 7, 7);
    apply_operand(CMD_SUB,    1, 99, 7, 7, 7, 7);
    apply_operand(CMD_UNUSED, 0, 0, 20'hFFFFF, 0, 20'hFFFFF, 0);
    drain_results();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase % 3)
        0:       idle_style = IDLE_HEAVY;
        1:       idle_style = IDLE_NONE;
        default: idle_style = IDLE_SPARSE;
      endcase
      repeat (110) send_beat(random_operand());
      if (phase == 2) drain_results();
    end
    drain_results();
    repeat (8) @(posedge clk);

    $display("run covered %0d result beats: %0d loads, %0d adds, %0d subtracts, %0d unused",
             sb.checked, sb.cmd_seen[CMD_LOAD], sb.cmd_seen[CMD_ADD],
             sb.cmd_seen[CMD_SUB], sb.cmd_seen[CMD_UNUSED]);
    $display("  %0d beats wrapped on overflow, %0d settled at zero", sb.overflows, sb.zeros);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sign_magnitude_multilimb_accumulator: match");
    end else begin
      $display("sign_magnitude_multilimb_accumulator: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("sign_magnitude_multilimb_accumulator: mismatch");
    $finish;
  end

endmodule
